// File: hw/rtl/spd_pkg.sv
package spd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned SHIFT_W = 24;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] HDR_BYTES    = 16'd4;
  localparam logic [LEN_W-1:0] HDR_LAST_POS = 16'd3;
  localparam logic [LEN_W-1:0] MIN_LEN_RST  = 16'd8;
  localparam logic [LEN_W-1:0] MAX_LEN_RST  = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN = 2'd0,
    CFG_MAX_LEN = 2'd1
  } cfg_idx_t;

  // Framing phase of the parser.
  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  // A group of result items handed from the parser to the emitter. The
  // bytes leave from the top of data, one per transfer, with rising index.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] data;
    logic [LEN_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic              last;
    logic              bad;
  } burst_t;

endpackage

// File: hw/rtl/spd_in_if.sv
interface spd_in_if import spd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/spd_out_if.sv
interface spd_out_if import spd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pdu_byte;
  logic [LEN_W-1:0]  byte_index;
  logic              pdu_last;
  logic              bad_length;

  modport source (output valid, output pdu_byte, output byte_index,
                  output pdu_last, output bad_length, input ready);
  modport sink   (input valid, input pdu_byte, input byte_index,
                  input pdu_last, input bad_length, output ready);
endinterface

// File: hw/rtl/spd_parse.sv
module spd_parse import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [LEN_W-1:0]  min_len,
  input  logic [LEN_W-1:0]  max_len,
  output burst_t            burst
);

  phase_t              phase_r, phase_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;

  logic                hdr_done;
  logic [LEN_W-1:0]    hdr_len;
  logic                reject;
  logic [LEN_W:0]      idx_inc;
  logic                body_last;

  assign hdr_done  = (count_r == HDR_LAST_POS);
  assign hdr_len   = {shift_r[BYTE_W-1:0], rx_byte};
  // Any length with bits above 16 set is out of range of both bounds.
  assign reject    = (shift_r[SHIFT_W-1:BYTE_W] != '0) || (hdr_len < HDR_BYTES) ||
                     (hdr_len < min_len) || (hdr_len > max_len);
  assign idx_inc   = {1'b0, count_r} + {{LEN_W{1'b0}}, 1'b1};
  assign body_last = (idx_inc >= {1'b0, len_r});

  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_done && !reject && hdr_len != HDR_BYTES) begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_last) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: phase_nxt = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    shift_nxt = shift_r;
    len_nxt   = len_r;
    burst     = '0;
    if (take) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (!hdr_done) begin
            shift_nxt = {shift_r[SHIFT_W-BYTE_W-1:0], rx_byte};
            count_nxt = count_r + 16'd1;
          end else begin
            burst.valid = 1'b1;
            shift_nxt   = '0;
            if (reject) begin
              burst.cnt  = 3'd1;
              burst.last = 1'b1;
              burst.bad  = 1'b1;
              count_nxt  = '0;
              len_nxt    = '0;
            end else begin
              burst.data = {shift_r, rx_byte};
              burst.cnt  = 3'd4;
              burst.last = (hdr_len == HDR_BYTES);
              if (hdr_len == HDR_BYTES) begin
                count_nxt = '0;
                len_nxt   = '0;
              end else begin
                count_nxt = HDR_BYTES;
                len_nxt   = hdr_len;
              end
            end
          end
        end
        PH_BODY: begin
          burst.valid = 1'b1;
          burst.data  = {rx_byte, {SHIFT_W{1'b0}}};
          burst.idx   = count_r;
          burst.cnt   = 3'd1;
          burst.last  = body_last;
          if (body_last) begin
            count_nxt = '0;
            len_nxt   = '0;
          end else begin
            count_nxt = idx_inc[LEN_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      count_r <= '0;
      shift_r <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      len_r   <= len_nxt;
    end
  end

  // Header collection never runs past the fourth byte.
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> count_r <= HDR_LAST_POS)
    else $error("header byte count out of range");

  // While in a body the index stays below the PDU length.
  a_body_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> (count_r < len_r && count_r >= HDR_BYTES))
    else $error("body index outside PDU");

  // An accepted header longer than four bytes enters the body at index four.
  a_body_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER && phase_nxt == PH_BODY) |=> count_r == HDR_BYTES)
    else $error("body entered at wrong index");

endmodule

// File: hw/rtl/spd_emit.sv
module spd_emit import spd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     burst,
  output logic       load_ready,
  spd_out_if.source  out_ch
);

  logic [WORD_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              last_r, last_nxt;
  logic              bad_r, bad_nxt;
  logic              xfer;

  assign xfer       = out_ch.valid && out_ch.ready;
  assign load_ready = (left_r == '0) || (left_r == 3'd1 && out_ch.ready);

  always_comb begin
    data_nxt = data_r;
    idx_nxt  = idx_r;
    left_nxt = left_r;
    last_nxt = last_r;
    bad_nxt  = bad_r;
    if (burst.valid && load_ready) begin
      data_nxt = burst.data;
      idx_nxt  = burst.idx;
      left_nxt = burst.cnt;
      last_nxt = burst.last;
      bad_nxt  = burst.bad;
    end else if (xfer) begin
      data_nxt = {data_r[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
      idx_nxt  = idx_r + 16'd1;
      left_nxt = left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
    data_r <= data_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_ch.valid      = (left_r != '0);
  assign out_ch.pdu_byte   = data_r[WORD_W-1:WORD_W-BYTE_W];
  assign out_ch.byte_index = idx_r;
  assign out_ch.pdu_last   = last_r && (left_r == 3'd1);
  assign out_ch.bad_length = bad_r;

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= 3'd4)
    else $error("emitter holds more than a header burst");

  // An error result is always a lone item.
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (bad_r && left_r != '0) |-> left_r == 3'd1)
    else $error("error result inside a burst");

  // A loaded burst is fully present on the next cycle.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (burst.valid && load_ready) |=> left_r == $past(burst.cnt))
    else $error("burst load lost items");

endmodule

// File: hw/rtl/smpp_pdu_deframer.sv
// SMPP PDU deframer.
// Bytes of a TCP stream enter on in_ch, one per transfer. The first four
// bytes of each PDU are its big-endian total length. On the fourth byte the
// length is checked against the min/max bounds written through the cfg_
// port (index 0: minimum, reset 8; index 1: maximum, reset 65535). A good
// length emits the four header bytes as four transfers on out_ch, indexes
// 0..3; each body byte then follows with its index, and the final byte of a
// PDU carries pdu_last. A bad length gives a single transfer with pdu_last
// and bad_length set and zero byte and index, and header collection starts
// over.
// An accepted byte gives its first result in the next cycle. Body bytes flow
// at one per cycle while out_ch is ready; the four-item header burst occupies
// the output register and holds in_ch.ready low until its last item is leaving.
// Input is taken whenever the output register is empty or its last pending
// item is leaving, so out_ch back-pressure stalls in_ch directly.
// Reset (rst_n, synchronous, active low) restores the default bounds,
// clears the framing state and drops any pending result.
module smpp_pdu_deframer import spd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  spd_in_if.sink               in_ch,
  spd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] max_len_r;
  logic             load_ready;
  logic             take;
  burst_t           burst;

  // Length bounds. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_LEN: min_len_r <= cfg_wdata;
        CFG_MAX_LEN: max_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A byte transfer happens only when the emitter can take its results.
  assign in_ch.ready = load_ready;
  assign take        = in_ch.valid && load_ready;

  spd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.rx_byte),
    .min_len (min_len_r),
    .max_len (max_len_r),
    .burst   (burst)
  );

  spd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst      (burst),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

  // Results only appear for accepted bytes.
  a_burst_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
    burst.valid |-> take)
    else $error("result produced without an input transfer");

  // A stalled output never accepts input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

endmodule
